FILE: hw/rtl/gpio_controller_edge_level_detect_assert.svh
// Assertion macros shared by the GPIO block.
`ifndef GPIO_CONTROLLER_EDGE_LEVEL_DETECT_ASSERT_SVH
`define GPIO_CONTROLLER_EDGE_LEVEL_DETECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCELD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCELD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/gceld_pkg.sv
package gceld_pkg;

   localparam int NumPinsDefault = 64;

   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   localparam logic [7:0] ADDR_FSEL_LAST  = 8'h18;
   localparam logic [7:0] ADDR_SET_LO     = 8'h1c;
   localparam logic [7:0] ADDR_SET_HI     = 8'h20;
   localparam logic [7:0] ADDR_CLR_LO     = 8'h28;
   localparam logic [7:0] ADDR_CLR_HI     = 8'h2c;
   localparam logic [7:0] ADDR_LEV_LO     = 8'h34;
   localparam logic [7:0] ADDR_LEV_HI     = 8'h38;
   localparam logic [7:0] ADDR_EDS_LO     = 8'h40;
   localparam logic [7:0] ADDR_EDS_HI     = 8'h44;
   localparam logic [7:0] ADDR_REN_LO     = 8'h4c;
   localparam logic [7:0] ADDR_REN_HI     = 8'h50;
   localparam logic [7:0] ADDR_FEN_LO     = 8'h58;
   localparam logic [7:0] ADDR_FEN_HI     = 8'h5c;
   localparam logic [7:0] ADDR_HEN_LO     = 8'h64;
   localparam logic [7:0] ADDR_HEN_HI     = 8'h68;
   localparam logic [7:0] ADDR_LEN_LO     = 8'h70;
   localparam logic [7:0] ADDR_LEN_HI     = 8'h74;
   localparam logic [7:0] ADDR_AREN_LO    = 8'h7c;
   localparam logic [7:0] ADDR_AREN_HI    = 8'h80;
   localparam logic [7:0] ADDR_AFEN_LO    = 8'h88;
   localparam logic [7:0] ADDR_AFEN_HI    = 8'h8c;
   localparam logic [7:0] ADDR_PUD        = 8'h94;
   localparam logic [7:0] ADDR_PUDCLK_LO  = 8'h98;
   localparam logic [7:0] ADDR_PUDCLK_HI  = 8'h9c;

   localparam logic [2:0] FSEL_OUTPUT = 3'd1;
   localparam logic [1:0] PULL_DN     = 2'd1;
   localparam logic [1:0] PULL_UP     = 2'd2;

   localparam int PinsPerFselWord = 10;

endpackage

FILE: hw/rtl/gpio_controller_edge_level_detect.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    command, address, write_data, pin_levels
// rsp_      out        rsp_valid/rsp_ready    read_data, error, pin drive/enable/pull, irq
//
// One request per cycle while req_ready; its response is registered and shows next cycle.
// All register state updates in the same cycle the request is accepted.
// req_ready is low only while a response is held and rsp_ready is low.
// Synchronous active-high reset clears the register map, function selects, pulls and
// rsp_valid; the response data registers are loaded only when a request is accepted.
`include "gpio_controller_edge_level_detect_assert.svh"

module gpio_controller_edge_level_detect #(
   parameter int NUM_PINS = gceld_pkg::NumPinsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_address,
   input  logic [31:0] req_write_data,
   input  logic [63:0] req_pin_levels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_error,
   output logic [63:0] rsp_pin_drive,
   output logic [63:0] rsp_pin_output_enable,
   output logic [63:0] rsp_pull_up,
   output logic [63:0] rsp_pull_dn,
   output logic [1:0]  rsp_irq_pending
);

   localparam logic [63:0] PinMask = {64{1'b1}} >> (64 - NUM_PINS);

   logic [63:0][2:0] fsel_ff, fsel_in;
   logic [63:0] latch_ff, latch_in;
   logic [63:0] level_ff, level_in;
   logic [63:0] eds_ff, eds_in;
   logic [63:0] ren_ff, ren_in;
   logic [63:0] fen_ff, fen_in;
   logic [63:0] hen_ff, hen_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] aren_ff, aren_in;
   logic [63:0] afen_ff, afen_in;
   logic [1:0]  pud_ff, pud_in;
   logic [63:0] pudclk_ff, pudclk_in;
   logic [63:0] pu_ff, pu_in;
   logic [63:0] pd_ff, pd_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rd_ff, rd_in;
   logic        err_ff, err_in;
   logic [63:0] drive_ff;
   logic [63:0] oe_ff, oe_in;
   logic [63:0] out_pu_ff;
   logic [63:0] out_pd_ff;
   logic [1:0]  irq_ff, irq_in;

   logic        accept;
   logic        is_bus;
   logic        wr;
   logic        hi;
   logic        mapped;
   logic [2:0]  fsel_word;
   logic [31:0] rd;
   logic [63:0] wbits;
   logic [63:0] keep;
   logic [63:0] nw;
   logic [63:0] ev;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   function automatic logic [63:0] put_word(input logic [63:0] cur, input logic [63:0] bits,
                                            input logic upper);
      logic [63:0] k;
      k = upper ? 64'h0000_0000_ffff_ffff : 64'hffff_ffff_0000_0000;
      return (cur & k) | bits;
   endfunction

   function automatic logic [31:0] get_word(input logic [63:0] v, input logic upper);
      return upper ? v[63:32] : v[31:0];
   endfunction

   always_comb begin
      fsel_in   = fsel_ff;
      latch_in  = latch_ff;
      level_in  = level_ff;
      eds_in    = eds_ff;
      ren_in    = ren_ff;
      fen_in    = fen_ff;
      hen_in    = hen_ff;
      len_in    = len_ff;
      aren_in   = aren_ff;
      afen_in   = afen_ff;
      pud_in    = pud_ff;
      pudclk_in = pudclk_ff;
      pu_in     = pu_ff;
      pd_in     = pd_ff;
      rd        = '0;
      mapped    = 1'b1;
      hi        = 1'b0;
      is_bus    = (req_command == gceld_pkg::CMD_READ) || (req_command == gceld_pkg::CMD_WRITE);
      wr        = (req_command == gceld_pkg::CMD_WRITE);
      fsel_word = req_address[4:2];
      keep      = '0;
      nw        = req_pin_levels & PinMask;
      ev        = '0;

      case (req_address)
         gceld_pkg::ADDR_SET_HI, gceld_pkg::ADDR_CLR_HI, gceld_pkg::ADDR_LEV_HI,
         gceld_pkg::ADDR_EDS_HI, gceld_pkg::ADDR_REN_HI, gceld_pkg::ADDR_FEN_HI,
         gceld_pkg::ADDR_HEN_HI, gceld_pkg::ADDR_LEN_HI, gceld_pkg::ADDR_AREN_HI,
         gceld_pkg::ADDR_AFEN_HI, gceld_pkg::ADDR_PUDCLK_HI: begin
            hi = 1'b1;
         end
         default: begin
            hi = 1'b0;
         end
      endcase
      wbits = (hi ? {req_write_data, 32'd0} : {32'd0, req_write_data}) & PinMask;

      case (gceld_pkg::cmd_type'(req_command))
         gceld_pkg::CMD_READ, gceld_pkg::CMD_WRITE: begin
            if (req_address[1:0] != 2'd0) begin
               mapped = 1'b0;
            end else if (req_address <= gceld_pkg::ADDR_FSEL_LAST) begin
               for (int p = 0; p < 64; p++) begin
                  if ((p / gceld_pkg::PinsPerFselWord) == int'(fsel_word) && p < NUM_PINS) begin
                     if (wr) begin
                        fsel_in[p] = req_write_data[3 * (p % gceld_pkg::PinsPerFselWord) +: 3];
                     end else begin
                        rd[3 * (p % gceld_pkg::PinsPerFselWord) +: 3] = fsel_ff[p];
                     end
                  end
               end
            end else begin
               case (req_address)
                  gceld_pkg::ADDR_SET_LO, gceld_pkg::ADDR_SET_HI: begin
                     if (wr) latch_in = latch_ff | wbits;
                  end
                  gceld_pkg::ADDR_CLR_LO, gceld_pkg::ADDR_CLR_HI: begin
                     if (wr) latch_in = latch_ff & ~wbits;
                  end
                  gceld_pkg::ADDR_LEV_LO, gceld_pkg::ADDR_LEV_HI: begin
                     rd = get_word(level_ff, hi);
                  end
                  gceld_pkg::ADDR_EDS_LO, gceld_pkg::ADDR_EDS_HI: begin
                     if (wr) eds_in = eds_ff & ~wbits;
                     rd = get_word(eds_ff, hi);
                  end
                  gceld_pkg::ADDR_REN_LO, gceld_pkg::ADDR_REN_HI: begin
                     if (wr) ren_in = put_word(ren_ff, wbits, hi);
                     rd = get_word(ren_ff, hi);
                  end
                  gceld_pkg::ADDR_FEN_LO, gceld_pkg::ADDR_FEN_HI: begin
                     if (wr) fen_in = put_word(fen_ff, wbits, hi);
                     rd = get_word(fen_ff, hi);
                  end
                  gceld_pkg::ADDR_HEN_LO, gceld_pkg::ADDR_HEN_HI: begin
                     if (wr) hen_in = put_word(hen_ff, wbits, hi);
                     rd = get_word(hen_ff, hi);
                  end
                  gceld_pkg::ADDR_LEN_LO, gceld_pkg::ADDR_LEN_HI: begin
                     if (wr) len_in = put_word(len_ff, wbits, hi);
                     rd = get_word(len_ff, hi);
                  end
                  gceld_pkg::ADDR_AREN_LO, gceld_pkg::ADDR_AREN_HI: begin
                     if (wr) aren_in = put_word(aren_ff, wbits, hi);
                     rd = get_word(aren_ff, hi);
                  end
                  gceld_pkg::ADDR_AFEN_LO, gceld_pkg::ADDR_AFEN_HI: begin
                     if (wr) afen_in = put_word(afen_ff, wbits, hi);
                     rd = get_word(afen_ff, hi);
                  end
                  gceld_pkg::ADDR_PUD: begin
                     if (wr) pud_in = req_write_data[1:0];
                     rd = {30'd0, pud_ff};
                  end
                  gceld_pkg::ADDR_PUDCLK_LO, gceld_pkg::ADDR_PUDCLK_HI: begin
                     // Every pin whose clock bit is written as one latches the pull control.
                     if (wr) begin
                        pudclk_in = put_word(pudclk_ff, wbits, hi);
                        pu_in = (pu_ff & ~wbits) | (wbits & {64{pud_ff == gceld_pkg::PULL_UP}});
                        pd_in = (pd_ff & ~wbits) | (wbits & {64{pud_ff == gceld_pkg::PULL_DN}});
                     end
                     rd = get_word(pudclk_ff, hi);
                  end
                  default: begin
                     mapped = 1'b0;
                  end
               endcase
            end
         end
         gceld_pkg::CMD_SAMPLE: begin
            // Edges compare the new sample with the last one held in the level register.
            ev = ((nw & ~level_ff) & (ren_ff | aren_ff))
               | ((~nw & level_ff) & (fen_ff | afen_ff))
               | (nw & hen_ff) | (~nw & len_ff);
            eds_in   = eds_ff | (ev & PinMask);
            level_in = nw;
         end
         default: begin
         end
      endcase

      keep   = eds_in;
      rd_in  = (is_bus && !wr && mapped) ? rd : 32'd0;
      err_in = is_bus && !mapped;
      irq_in = {keep[63:32] != 32'd0, keep[31:0] != 32'd0};
      for (int p = 0; p < 64; p++) begin
         oe_in[p] = (fsel_in[p] == gceld_pkg::FSEL_OUTPUT) && PinMask[p];
      end
      rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff      <= '0;
         latch_ff     <= '0;
         level_ff     <= '0;
         eds_ff       <= '0;
         ren_ff       <= '0;
         fen_ff       <= '0;
         hen_ff       <= '0;
         len_ff       <= '0;
         aren_ff      <= '0;
         afen_ff      <= '0;
         pud_ff       <= '0;
         pudclk_ff    <= '0;
         pu_ff        <= '0;
         pd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fsel_ff   <= fsel_in;
            latch_ff  <= latch_in;
            level_ff  <= level_in;
            eds_ff    <= eds_in;
            ren_ff    <= ren_in;
            fen_ff    <= fen_in;
            hen_ff    <= hen_in;
            len_ff    <= len_in;
            aren_ff   <= aren_in;
            afen_ff   <= afen_in;
            pud_ff    <= pud_in;
            pudclk_ff <= pudclk_in;
            pu_ff     <= pu_in;
            pd_ff     <= pd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= rd_in;
         err_ff    <= err_in;
         drive_ff  <= latch_in & PinMask;
         oe_ff     <= oe_in;
         out_pu_ff <= pu_in & PinMask;
         out_pd_ff <= pd_in & PinMask;
         irq_ff    <= irq_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rd_ff;
   assign rsp_error             = err_ff;
   assign rsp_pin_drive         = drive_ff;
   assign rsp_pin_output_enable = oe_ff;
   assign rsp_pull_up           = out_pu_ff;
   assign rsp_pull_dn           = out_pd_ff;
   assign rsp_irq_pending       = irq_ff;

   `GCELD_ASSERT_NEXT(a_sample_no_error, clock, reset,
      accept && req_command == gceld_pkg::CMD_SAMPLE, !rsp_error,
      "pin sample flagged a bus error")
   `GCELD_ASSERT_NEXT(a_write_reads_zero, clock, reset,
      accept && req_command == gceld_pkg::CMD_WRITE, rsp_read_data == 32'd0,
      "bus write returned nonzero read data")
   `GCELD_ASSERT_IMPL(a_pull_exclusive, clock, reset,
      rsp_valid, (rsp_pull_up & rsp_pull_dn) == 64'd0,
      "pin reported with both pull up and pull down")
   `GCELD_ASSERT_IMPL(a_unused_pins_quiet, clock, reset,
      rsp_valid, ((rsp_pin_drive | rsp_pin_output_enable) & ~PinMask) == 64'd0,
      "pin beyond the configured count is driven or enabled")

endmodule
